// ===== hdl/ncc_pkg.sv =====
package ncc_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned MINCNT_W  = 24;
  localparam int unsigned OIDX_W    = 6;
  localparam int unsigned OHITS_W   = 24;
  localparam int unsigned OUSE_W    = 7;
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  // Commands carried in the input tuser
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PRUNE    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Micro-operations driven into the datapath
  localparam int unsigned OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
  localparam logic [OP_W-1:0] OP_START    = 4'd1;
  localparam logic [OP_W-1:0] OP_CLR      = 4'd2;
  localparam logic [OP_W-1:0] OP_APP      = 4'd3;
  localparam logic [OP_W-1:0] OP_CHK      = 4'd4;
  localparam logic [OP_W-1:0] OP_SCAN_CLS = 4'd5;
  localparam logic [OP_W-1:0] OP_SCAN_PRN = 4'd6;
  localparam logic [OP_W-1:0] OP_UPD      = 4'd7;
  localparam logic [OP_W-1:0] OP_SETN     = 4'd8;
  localparam logic [OP_W-1:0] OP_EMIT     = 4'd9;

  // Sequencer jump conditions
  localparam int unsigned COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
  localparam logic [COND_W-1:0] C_GOTO     = 3'd1;
  localparam logic [COND_W-1:0] C_DISPATCH = 3'd2;
  localparam logic [COND_W-1:0] C_EMPTY    = 3'd3;
  localparam logic [COND_W-1:0] C_SCAN     = 3'd4;
  localparam logic [COND_W-1:0] C_OUT      = 3'd5;

  // Program addresses
  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] S_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] S_CLR      = 4'd1;
  localparam logic [UPC_W-1:0] S_APP      = 4'd2;
  localparam logic [UPC_W-1:0] S_CLS      = 4'd3;
  localparam logic [UPC_W-1:0] S_CLS_SCAN = 4'd4;
  localparam logic [UPC_W-1:0] S_CLS_UPD  = 4'd5;
  localparam logic [UPC_W-1:0] S_PRN_SCAN = 4'd6;
  localparam logic [UPC_W-1:0] S_PRN_END  = 4'd7;
  localparam logic [UPC_W-1:0] S_EMIT     = 4'd8;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  target;
    logic [OP_W-1:0]   op;
  } uword_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            go;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic empty;
    logic busy;
    logic out_block;
  } flags_t;

  function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

// ===== hdl/nearest_color_centroid_classify.sv =====
// Channel   Ports                      Payload
// in        in_tvalid/in_tready        tuser: command; tdata: red, green, blue
// out       out_tvalid/out_tready      tuser: status; tdata: index, hits, entries in use
// cfg       cfg_valid/cfg_ready        cfg_data: min_count
//
// From acceptance to out_tvalid: clear and append run their own step, then emit; classify
// checks the table (an empty one goes straight to emit), scans, updates the hit count and
// emits; prune scans, sets the entry count and emits. The scan reads one entry per cycle,
// then drains its read and compare stages. After emit, the idle step takes the next input.
// Reset (rst_n low, synchronous) empties the table and sets min_count to 0.
// A result waits in the output register; a stalled output holds the next result at its
// final step.
module nearest_color_centroid_classify #(
  parameter int unsigned MAX_CENTROIDS = 64,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic [1:0]  in_tuser,   // command [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // match_index [5:0], match_hits [29:6],
                                  // entries_in_use [36:30], zero [39:37]
  output logic [1:0]  out_tuser,  // status [1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data    // min_count [23:0]
);
  import ncc_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  assign cfg_ready = 1'b1;

  ncc_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .flags     (flags),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  ncc_dpath #(
    .MAX_CENTROIDS (MAX_CENTROIDS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .flags      (flags),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hdl/ncc_ram.sv =====
module ncc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ncc_useq.sv =====
module ncc_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [1:0]      in_cmd,
  input  ncc_pkg::flags_t flags,
  output logic            in_tready,
  output ncc_pkg::ctrl_t  ctrl
);
  import ncc_pkg::*;

  logic [UPC_W-1:0] pc_r, pc_nxt;
  uword_t           uw;

  // Control store: one word per step
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      S_IDLE:     w = '{cond: C_DISPATCH, target: S_IDLE, op: OP_START};
      S_CLR:      w = '{cond: C_GOTO,     target: S_EMIT, op: OP_CLR};
      S_APP:      w = '{cond: C_GOTO,     target: S_EMIT, op: OP_APP};
      S_CLS:      w = '{cond: C_EMPTY,    target: S_EMIT, op: OP_CHK};
      S_CLS_SCAN: w = '{cond: C_SCAN,     target: S_IDLE, op: OP_SCAN_CLS};
      S_CLS_UPD:  w = '{cond: C_GOTO,     target: S_EMIT, op: OP_UPD};
      S_PRN_SCAN: w = '{cond: C_SCAN,     target: S_IDLE, op: OP_SCAN_PRN};
      S_PRN_END:  w = '{cond: C_NEXT,     target: S_IDLE, op: OP_SETN};
      S_EMIT:     w = '{cond: C_OUT,      target: S_IDLE, op: OP_EMIT};
      default:    w = '{cond: C_GOTO,     target: S_IDLE, op: OP_NOP};
    endcase
    return w;
  endfunction

  // Map a command to its entry step
  function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] cmd);
    logic [UPC_W-1:0] a;
    unique case (cmd)
      CMD_CLEAR:    a = S_CLR;
      CMD_APPEND:   a = S_APP;
      CMD_CLASSIFY: a = S_CLS;
      default:      a = S_PRN_SCAN;
    endcase
    return a;
  endfunction

  assign uw        = ucode(pc_r);
  assign in_tready = (uw.cond == C_DISPATCH);

  // Next step and execute strobe
  always_comb begin
    pc_nxt  = pc_r + 1'b1;
    ctrl.op = uw.op;
    ctrl.go = 1'b1;
    unique case (uw.cond)
      C_NEXT:     pc_nxt = pc_r + 1'b1;
      C_GOTO:     pc_nxt = uw.target;
      C_DISPATCH: begin
        ctrl.go = in_tvalid;
        pc_nxt  = in_tvalid ? dispatch(in_cmd) : pc_r;
      end
      C_EMPTY:    pc_nxt = flags.empty ? uw.target : pc_r + 1'b1;
      C_SCAN:     pc_nxt = flags.busy ? pc_r : pc_r + 1'b1;
      C_OUT: begin
        ctrl.go = !flags.out_block;
        pc_nxt  = flags.out_block ? pc_r : uw.target;
      end
      default:    pc_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hdl/ncc_dpath.sv =====
module ncc_dpath #(
  parameter int unsigned MAX_CENTROIDS = 64,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ncc_pkg::ctrl_t                    ctrl,
  output ncc_pkg::flags_t                   flags,
  input  logic [ncc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              cfg_valid,
  input  logic [ncc_pkg::MINCNT_W-1:0]      cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ncc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [ncc_pkg::STATUS_W-1:0]      out_tuser
);
  import ncc_pkg::*;

  localparam int unsigned IDX_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int unsigned N_W   = $clog2(MAX_CENTROIDS + 1);
  localparam int unsigned EW    = 3 * COLOR_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [N_W-1:0]        N_FULL  = N_W'(MAX_CENTROIDS);

  // Table fill and scan pointers
  logic [N_W-1:0]      n_r, n_nxt;
  logic [N_W-1:0]      i_r, i_nxt;
  logic [N_W-1:0]      w_r, w_nxt;
  // Latched pixel
  logic [COLOR_W-1:0]  pr_r, pg_r, pb_r;
  // Read stage
  logic                rdv_r, rdv_nxt;
  logic [IDX_W-1:0]    ridx_r;
  // Evaluate stage
  logic                dv_r, dv_nxt;
  logic [IDX_W-1:0]    e_idx_r;
  logic [EW-1:0]       e_word_r;
  logic [DIST_W-1:0]   e_dist_r;
  // Running best
  logic [IDX_W-1:0]    best_idx_r;
  logic [DIST_W-1:0]   best_dist_r;
  logic [EW-1:0]       best_word_r;
  // Result holding
  logic [IDX_W-1:0]    res_idx_r;
  logic [COUNT_BITS-1:0] res_hits_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [MINCNT_W-1:0] min_count_r;
  // Output register
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [STATUS_W-1:0]   out_tuser_r;

  // Memory port signals
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  logic              op_go;
  logic              scan;
  logic [COLOR_W-1:0] cr, cg, cb;
  logic [DIST_W-1:0] ent_dist;
  logic              take_best;
  logic              keep;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]       idx_ext, hits_ext, use_ext;

  assign op_go = ctrl.go;
  assign scan  = (ctrl.op == OP_SCAN_CLS) || (ctrl.op == OP_SCAN_PRN);

  ncc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CENTROIDS),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Distance of the entry just read
  assign cr   = ram_rdata[EW-1 -: COLOR_W];
  assign cg   = ram_rdata[EW-1-COLOR_W -: COLOR_W];
  assign cb   = ram_rdata[EW-1-2*COLOR_W -: COLOR_W];
  assign ent_dist = DIST_W'(sq_diff(pr_r, cr)) + DIST_W'(sq_diff(pg_r, cg))
                  + DIST_W'(sq_diff(pb_r, cb));

  // Evaluate-stage decisions
  assign take_best = (e_idx_r == '0) || (e_dist_r < best_dist_r);
  assign keep      = 32'(e_word_r[COUNT_BITS-1:0]) > 32'(min_count_r);
  assign cnt_inc   = (best_word_r[COUNT_BITS-1:0] == CNT_MAX) ? CNT_MAX
                   : best_word_r[COUNT_BITS-1:0] + 1'b1;

  assign flags.empty     = (n_r == '0);
  assign flags.busy      = (i_r < n_r) || rdv_r || dv_r;
  assign flags.out_block = out_tvalid_r && !out_tready;

  assign idx_ext  = 32'(res_idx_r);
  assign hits_ext = 32'(res_hits_r);
  assign use_ext  = 32'(n_r);

  // Memory access per micro-operation
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n_r[IDX_W-1:0];
    ram_wdata = {pr_r, pg_r, pb_r, {COUNT_BITS{1'b0}}};
    ram_re    = 1'b0;
    ram_raddr = i_r[IDX_W-1:0];
    if (ctrl.op == OP_APP && n_r != N_FULL) begin
      ram_we = 1'b1;
    end
    if (ctrl.op == OP_UPD) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_r;
      ram_wdata = {best_word_r[EW-1:COUNT_BITS], cnt_inc};
    end
    if (ctrl.op == OP_SCAN_PRN && dv_r && keep) begin
      ram_we    = 1'b1;
      ram_waddr = w_r[IDX_W-1:0];
      ram_wdata = {e_word_r[EW-1:COUNT_BITS], {COUNT_BITS{1'b0}}};
    end
    if (scan && i_r < n_r) begin
      ram_re = 1'b1;
    end
  end

  // Control next state
  always_comb begin
    n_nxt          = n_r;
    i_nxt          = i_r;
    w_nxt          = w_r;
    rdv_nxt        = 1'b0;
    dv_nxt         = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (ctrl.op)
      OP_START: begin
        if (op_go) begin
          i_nxt = '0;
          w_nxt = '0;
        end
      end
      OP_CLR: n_nxt = '0;
      OP_APP: begin
        if (n_r != N_FULL) begin
          n_nxt = n_r + 1'b1;
        end
      end
      OP_SCAN_CLS, OP_SCAN_PRN: begin
        rdv_nxt = (i_r < n_r);
        dv_nxt  = rdv_r;
        if (i_r < n_r) begin
          i_nxt = i_r + 1'b1;
        end
        if (ctrl.op == OP_SCAN_PRN && dv_r && keep) begin
          w_nxt = w_r + 1'b1;
        end
      end
      OP_SETN: n_nxt = w_r;
      OP_EMIT: begin
        if (op_go) begin
          out_tvalid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= '0;
      i_r          <= '0;
      w_r          <= '0;
      rdv_r        <= 1'b0;
      dv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
      min_count_r  <= '0;
    end else begin
      n_r          <= n_nxt;
      i_r          <= i_nxt;
      w_r          <= w_nxt;
      rdv_r        <= rdv_nxt;
      dv_r         <= dv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        min_count_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    // Latch the pixel and clear the result on a new transaction
    if (ctrl.op == OP_START && op_go) begin
      pr_r         <= in_tdata[COLOR_W-1:0];
      pg_r         <= in_tdata[2*COLOR_W-1:COLOR_W];
      pb_r         <= in_tdata[3*COLOR_W-1:2*COLOR_W];
      res_idx_r    <= '0;
      res_hits_r   <= '0;
      res_status_r <= ST_OK;
    end
    if (ctrl.op == OP_APP && n_r == N_FULL) begin
      res_status_r <= ST_FULL;
    end
    if (ctrl.op == OP_CHK && n_r == '0) begin
      res_status_r <= ST_EMPTY;
    end
    // Read stage into evaluate stage
    if (scan) begin
      ridx_r <= i_r[IDX_W-1:0];
    end
    if (rdv_r) begin
      e_idx_r  <= ridx_r;
      e_word_r <= ram_rdata;
      e_dist_r <= ent_dist;
    end
    // Track the nearest entry, first index wins a tie
    if (ctrl.op == OP_SCAN_CLS && dv_r && take_best) begin
      best_idx_r  <= e_idx_r;
      best_dist_r <= e_dist_r;
      best_word_r <= e_word_r;
    end
    if (ctrl.op == OP_UPD) begin
      res_idx_r  <= best_idx_r;
      res_hits_r <= cnt_inc;
    end
    // Load the output register
    if (ctrl.op == OP_EMIT && op_go) begin
      out_tdata_r <= {3'b000, use_ext[OUSE_W-1:0], hits_ext[OHITS_W-1:0],
                      idx_ext[OIDX_W-1:0]};
      out_tuser_r <= res_status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== sim/nearest_color_centroid_classify_test.sv =====
`timescale 1ns / 100ps

module nearest_color_centroid_classify_test;
  import ncc_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [OHITS_W-1:0] HITS_MAX = '1;

  // One classifier response as it leaves the block
  typedef struct packed {
    logic [OIDX_W-1:0]   index;
    logic [OHITS_W-1:0]  hits;
    logic [OUSE_W-1:0]   in_use;
    logic [STATUS_W-1:0] status;
  } match_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;   // red [7:0], green [15:8], blue [23:16]
  logic [CMD_W-1:0]      in_tuser  = CMD_CLEAR;  // command [1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // match_index [5:0], match_hits [29:6],
                                     // entries_in_use [36:30], zero [39:37]
  logic [STATUS_W-1:0]   out_tuser;  // status [1:0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MINCNT_W-1:0]   cfg_data  = '0;  // min_count [23:0]

  // Shadow copy of the centroid table and the prune threshold
  logic [COLOR_W-1:0] pal_red   [TABLE_DEPTH];
  logic [COLOR_W-1:0] pal_green [TABLE_DEPTH];
  logic [COLOR_W-1:0] pal_blue  [TABLE_DEPTH];
  logic [OHITS_W-1:0] pal_hits  [TABLE_DEPTH];
  int unsigned        pal_size   = 0;
  logic [MINCNT_W-1:0] keep_above = '0;

  match_t      awaited_matches[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  bit          steady         = 1'b0;

  nearest_color_centroid_classify dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Apply one command to the shadow table and return the response it causes.
  // The saturating cap on a hit count is modeled, though no run this short gets there.
  function automatic match_t palette_response(input logic [CMD_W-1:0] cmd,
                                              input logic [COLOR_W-1:0] r,
                                              input logic [COLOR_W-1:0] g,
                                              input logic [COLOR_W-1:0] b);
    match_t      m;
    int          dr, dg, db;
    int unsigned i, sq_sum, best, best_sum, kept;
    m = '0;
    case (cmd)
      CMD_CLEAR: begin
        pal_size = 0;
      end
      CMD_APPEND: begin
        if (pal_size >= TABLE_DEPTH) begin
          m.status = ST_FULL;
        end else begin
          pal_red[pal_size]   = r;
          pal_green[pal_size] = g;
          pal_blue[pal_size]  = b;
          pal_hits[pal_size]  = '0;
          pal_size++;
        end
      end
      CMD_CLASSIFY: begin
        if (pal_size == 0) begin
          m.status = ST_EMPTY;
        end else begin
          best = 0;
          best_sum = 0;
          // strict less-than keeps the lowest index on a tie
          for (i = 0; i < pal_size; i++) begin
            dr = int'(r) - int'(pal_red[i]);
            dg = int'(g) - int'(pal_green[i]);
            db = int'(b) - int'(pal_blue[i]);
            sq_sum = unsigned'(dr * dr + dg * dg + db * db);
            if (i == 0 || sq_sum < best_sum) begin
              best_sum = sq_sum;
              best = i;
            end
          end
          if (pal_hits[best] != HITS_MAX) pal_hits[best]++;
          m.index = OIDX_W'(best);
          m.hits  = pal_hits[best];
        end
      end
      default: begin
        // compact in order, keeping entries hit more than the threshold
        kept = 0;
        for (i = 0; i < pal_size; i++) begin
          if (pal_hits[i] > keep_above) begin
            pal_red[kept]   = pal_red[i];
            pal_green[kept] = pal_green[i];
            pal_blue[kept]  = pal_blue[i];
            pal_hits[kept]  = '0;
            kept++;
          end
        end
        pal_size = kept;
      end
    endcase
    m.in_use = OUSE_W'(pal_size);
    return m;
  endfunction

  // Track register writes and predict each accepted command
  always @(posedge clk) begin
    match_t predicted;
    if (rst_n && cfg_valid && cfg_ready) keep_above = cfg_data;
    if (rst_n && in_tvalid && in_tready) begin
      predicted = palette_response(in_tuser, in_tdata[7:0], in_tdata[15:8],
                                   in_tdata[23:16]);
      awaited_matches = {awaited_matches, predicted};
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_matches.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual tdata=%h tuser=%h",
                 $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = awaited_matches.pop_front();
        check_field("match_index", 32'(want.index), 32'(out_tdata[5:0]));
        check_field("match_hits", 32'(want.hits), 32'(out_tdata[29:6]));
        check_field("entries_in_use", 32'(want.in_use), 32'(out_tdata[36:30]));
        check_field("tdata padding", 32'd0, 32'(out_tdata[39:37]));
        check_field("status", 32'(want.status), 32'(out_tuser));
      end
    end
  end

  // Stall the result channel at random unless in a steady stretch
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 18);
  end

  // Hold one command on the input channel until the transaction completes
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [COLOR_W-1:0] r,
                              input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [COLOR_W-1:0] rand_color();
    return COLOR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [COLOR_W-1:0] nudge(input logic [COLOR_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[COLOR_W-1:0];
  endfunction

  // Classify a pixel close to a stored centroid so hits pile up on it (any pixel if empty)
  task automatic send_near_pixel();
    int unsigned k;
    if (pal_size == 0) begin
      send_command(CMD_CLASSIFY, rand_color(), rand_color(), rand_color());
    end else begin
      k = $urandom_range(0, pal_size - 1);
      send_command(CMD_CLASSIFY, nudge(pal_red[k]), nudge(pal_green[k]), nudge(pal_blue[k]));
    end
  endtask

  // Drop valid and wait until every response has arrived and the block is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_count(input logic [MINCNT_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Classify, prune and clear on an empty table
  task automatic test_empty_table();
    write_min_count('0);
    send_command(CMD_CLASSIFY, 8'd0, 8'd0, 8'd0);
    send_command(CMD_PRUNE, 8'd255, 8'd255, 8'd255);
    send_command(CMD_CLEAR, 8'd255, 8'd255, 8'd255);
    send_command(CMD_CLASSIFY, 8'd255, 8'd255, 8'd255);
  endtask

  // Equal distances resolve to the lowest index
  task automatic test_tie_break();
    send_command(CMD_APPEND, 8'd0, 8'd0, 8'd0);
    send_command(CMD_APPEND, 8'd2, 8'd0, 8'd0);
    send_command(CMD_APPEND, 8'd0, 8'd0, 8'd0);
    send_command(CMD_APPEND, 8'd255, 8'd255, 8'd255);
    send_command(CMD_CLASSIFY, 8'd1, 8'd0, 8'd0);
    send_command(CMD_CLASSIFY, 8'd0, 8'd0, 8'd0);
    send_command(CMD_CLASSIFY, 8'd2, 8'd0, 8'd0);
    send_command(CMD_CLASSIFY, 8'd255, 8'd255, 8'd255);
    send_command(CMD_CLASSIFY, 8'd128, 8'd128, 8'd128);
  endtask

  // Prune at several thresholds down to an empty table
  task automatic test_prune_threshold();
    write_min_count(24'd1);
    send_command(CMD_PRUNE, 8'd0, 8'd0, 8'd0);
    send_command(CMD_CLASSIFY, 8'd0, 8'd0, 8'd0);
    write_min_count('0);
    send_command(CMD_PRUNE, 8'd0, 8'd0, 8'd0);
    send_command(CMD_CLASSIFY, 8'd255, 8'd255, 8'd255);
    write_min_count(HITS_MAX);
    send_command(CMD_PRUNE, 8'd0, 8'd0, 8'd0);
    send_command(CMD_CLASSIFY, 8'd17, 8'd34, 8'd51);
  endtask

  // Fill every entry, overflow once, scan the whole table, then prune and append again
  task automatic test_full_table();
    int unsigned i;
    send_command(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0)
        send_command(CMD_APPEND, 8'd0, 8'd0, 8'd0);
      else if (i == TABLE_DEPTH - 1)
        send_command(CMD_APPEND, 8'd255, 8'd255, 8'd255);
      else
        send_command(CMD_APPEND, rand_color(), rand_color(), rand_color());
    end
    send_command(CMD_APPEND, 8'd9, 8'd9, 8'd9);
    send_command(CMD_CLASSIFY, 8'd0, 8'd0, 8'd0);
    send_command(CMD_CLASSIFY, 8'd255, 8'd255, 8'd255);
    repeat (4) send_near_pixel();
    write_min_count('0);
    send_command(CMD_PRUNE, 8'd0, 8'd0, 8'd0);
    send_command(CMD_APPEND, 8'd200, 8'd100, 8'd50);
    send_command(CMD_CLASSIFY, 8'd200, 8'd100, 8'd50);
  endtask

  // Phases of clear, fill, classify and prune, each under its own threshold
  task automatic test_random_traffic();
    int unsigned         phase, fill, pixels, pick, stop_at;
    logic [MINCNT_W-1:0] threshold;
    phase = 0;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      case (phase % 5)
        0: threshold = '0;
        1: threshold = MINCNT_W'($urandom_range(1, 4));
        2: threshold = HITS_MAX;
        3: threshold = MINCNT_W'($urandom);
        default: threshold = MINCNT_W'($urandom_range(0, 12));
      endcase
      write_min_count(threshold);
      steady = (phase >= 10 && phase < 15);
      if ($urandom_range(0, 9) != 0)
        send_command(CMD_CLEAR, rand_color(), rand_color(), rand_color());
      fill = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      repeat (fill)
        send_command(CMD_APPEND, rand_color(), rand_color(), rand_color());
      pixels = $urandom_range(5, 30);
      repeat (pixels) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          send_command(CMD_W'($urandom_range(0, 3)), rand_color(), rand_color(),
                       rand_color());
        else if (pick < 7)
          send_near_pixel();
        else
          send_command(CMD_CLASSIFY, rand_color(), rand_color(), rand_color());
      end
      send_command(CMD_PRUNE, rand_color(), rand_color(), rand_color());
      repeat ($urandom_range(2, 10)) send_near_pixel();
      if ($urandom_range(0, 2) == 0)
        send_command(CMD_PRUNE, rand_color(), rand_color(), rand_color());
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_tie_break();
    test_prune_threshold();
    test_full_table();
    test_random_traffic();
    settle();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ncc_pkg.sv
hdl/ncc_ram.sv
hdl/ncc_useq.sv
hdl/ncc_dpath.sv
hdl/nearest_color_centroid_classify.sv
sim/nearest_color_centroid_classify_test.sv
